// ----- sv/spl_pkg.sv -----
`timescale 1ns / 1ps
// spl_pkg: shared types, register codes and sizes for the 3x3 edge filter.
// No dependencies; imported by every module of the block but spl_chk.
package spl_pkg;

    localparam int PIXEL_BITS    = 8;
    localparam int MAX_WIDTH_DEF = 2048;

    // configuration port
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 16;
    localparam int WIDTH_BITS  = 12;
    localparam int HEIGHT_BITS = 16;
    localparam int MODE_BITS   = 2;
    localparam int ROW_BITS    = 16;

    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_FILTER_MODE  = 2'd2;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

    localparam logic [MODE_BITS-1:0] MODE_SOBEL   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_PREWITT = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_LAPLACE = 2'd2;

    // signed operator terms: Laplace reaches 5 * max, Sobel sum reaches 8 * max
    localparam int TERM_BITS = PIXEL_BITS + 4;

    // result queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = 3;

    typedef logic [PIXEL_BITS-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    // per-item control: vld means the item produces a result
    typedef struct packed {
        logic vld;
        logic border;
        logic fend;
    } item_ctl_t;

    typedef struct packed {
        pixel_t px;
        logic   fend;
    } out_item_t;

endpackage

// ----- sv/spl_pos.sv -----
`timescale 1ns / 1ps
// spl_pos: input and output raster position counters, priming, border and
// frame end decode. Depends on spl_pkg.
module spl_pos
    import spl_pkg::*;
#(
    parameter int   MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int  AW        = $clog2(MAX_WIDTH)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   acc,
    input  logic [WIDTH_BITS-1:0]  image_width,
    input  logic [HEIGHT_BITS-1:0] image_height,
    output logic [AW-1:0]          col,
    output item_ctl_t              ctl
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [AW-1:0]          in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_BITS-1:0]    in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [WW-1:0]          wid, wid_m1, ic1, oc1;
    logic [HEIGHT_BITS-1:0] hgt, hgt_m1;
    logic [AW-1:0]          ic0, oc0;
    logic [ROW_BITS-1:0]    ir0, or0;
    logic                   primed, border, fend;

    function automatic logic [ROW_BITS-1:0] row_inc(input logic [ROW_BITS-1:0] r);
        row_inc = (r == {ROW_BITS{1'b1}}) ? r : r + 1'b1;
    endfunction

    always_comb
    begin
        if (image_width < 12'd3)
            wid = WW'(3);
        else if (32'(image_width) > 32'(MAX_WIDTH))
            wid = WW'(MAX_WIDTH);
        else
            wid = WW'(image_width);
        wid_m1 = wid - 1'b1;
        hgt    = (image_height < 16'd3) ? 16'd3 : image_height;
        hgt_m1 = hgt - 1'b1;

        // input side
        if (WW'(in_col_reg) >= wid)
        begin
            ic0 = '0;
            ir0 = row_inc(in_row_reg);
        end
        else
        begin
            ic0 = in_col_reg;
            ir0 = in_row_reg;
        end
        primed = (ir0 >= 16'd2) || (ir0 == 16'd1 && ic0 != '0);
        ic1 = WW'(ic0) + 1'b1;
        if (ic1 >= wid)
        begin
            in_col_next = '0;
            in_row_next = row_inc(ir0);
        end
        else
        begin
            in_col_next = AW'(ic1);
            in_row_next = ir0;
        end

        // output side
        if (WW'(out_col_reg) >= wid)
        begin
            oc0 = '0;
            or0 = row_inc(out_row_reg);
        end
        else
        begin
            oc0 = out_col_reg;
            or0 = out_row_reg;
        end
        border = (or0 == '0) || (or0 >= hgt_m1) || (oc0 == '0) || (WW'(oc0) >= wid_m1);
        fend   = (or0 >= hgt_m1) && (WW'(oc0) >= wid_m1);
        oc1 = WW'(oc0) + 1'b1;
        if (!primed)
        begin
            out_col_next = out_col_reg;
            out_row_next = out_row_reg;
        end
        else if (oc1 >= wid)
        begin
            out_col_next = '0;
            out_row_next = row_inc(or0);
        end
        else
        begin
            out_col_next = AW'(oc1);
            out_row_next = or0;
        end

        // last pixel of the frame restarts all counters
        if (primed && fend)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (acc)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign col        = ic0;
    assign ctl.vld    = primed;
    assign ctl.border = border;
    assign ctl.fend   = fend;

endmodule

// ----- sv/spl_window.sv -----
`timescale 1ns / 1ps
// spl_window: two line stores and the 3x3 pixel window.
// Depends on spl_pkg.
module spl_window
    import spl_pkg::*;
#(
    parameter int   MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int  AW        = $clog2(MAX_WIDTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          acc,
    input  logic [AW-1:0] col,
    input  pixel_t        pix,
    input  item_ctl_t     ctl_in,
    output pixel_t [8:0]  win,
    output item_ctl_t     ctl_out
);

    pixel_t upper_mem  [MAX_WIDTH];
    pixel_t middle_mem [MAX_WIDTH];

    pixel_t       up_raw_reg, mid_rd_reg, fwd_data_reg, pix_reg, up_word;
    logic [AW-1:0] wr_col_reg;
    logic         fwd_reg, wr_vld_reg, s1_vld_reg;
    item_ctl_t    s1_ctl_reg, ctl_out_reg;
    pixel_t [8:0] win_reg;

    // middle store: read old entry, write the new pixel in the same transfer
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            mid_rd_reg      <= middle_mem[col];
            middle_mem[col] <= pix;
        end
    end

    // upper store takes the middle word in the cycle after it was read
    always_ff @(posedge clk)
    begin
        if (acc)
            up_raw_reg <= upper_mem[col];
        if (wr_vld_reg)
            upper_mem[wr_col_reg] <= mid_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pix_reg      <= pix;
            wr_col_reg   <= col;
            fwd_data_reg <= mid_rd_reg;
        end
    end

    // bypass when the pending upper write hits the address being read
    assign up_word = fwd_reg ? fwd_data_reg : up_raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg     <= 1'b0;
            wr_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s1_ctl_reg  <= '0;
            ctl_out_reg <= '0;
            win_reg     <= '0;
        end
        else
        begin
            wr_vld_reg  <= acc;
            s1_vld_reg  <= acc;
            s1_ctl_reg  <= acc ? ctl_in : '0;
            ctl_out_reg <= s1_vld_reg ? s1_ctl_reg : '0;
            if (acc)
                fwd_reg <= wr_vld_reg && (wr_col_reg == col);
            if (s1_vld_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]     <= win_reg[r*3 + 1];
                    win_reg[r*3 + 1] <= win_reg[r*3 + 2];
                end
                win_reg[2] <= up_word;
                win_reg[5] <= mid_rd_reg;
                win_reg[8] <= pix_reg;
            end
        end
    end

    assign win     = win_reg;
    assign ctl_out = ctl_out_reg;

endmodule

// ----- sv/spl_lane.sv -----
`timescale 1ns / 1ps
// spl_lane: operator datapath for one color channel, one register stage.
// Depends on spl_pkg.
module spl_lane
    import spl_pkg::*;
(
    input  logic                 clk,
    input  chan_t [8:0]          win,
    input  logic [MODE_BITS-1:0] mode,
    input  logic                 border,
    output chan_t                result
);

    localparam int TW = TERM_BITS;
    localparam logic signed [TW-1:0] CH_MAX = TW'((1 << PIXEL_BITS) - 1);

    logic signed [TW-1:0] v [9];
    logic signed [TW-1:0] term_a, term_b, term_a_reg, term_b_reg;
    logic signed [TW-1:0] mag_a, mag_b, total;
    logic                 use_abs, use_abs_reg;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            v[k] = signed'(TW'(win[k]));
        term_a  = v[4];
        term_b  = '0;
        use_abs = 1'b0;
        if (!border)
        begin
            case (mode)
                MODE_SOBEL:
                begin
                    term_a  = v[2] + (v[5] <<< 1) + v[8] - v[0] - (v[3] <<< 1) - v[6];
                    term_b  = v[6] + (v[7] <<< 1) + v[8] - v[0] - (v[1] <<< 1) - v[2];
                    use_abs = 1'b1;
                end
                MODE_PREWITT:
                begin
                    term_a  = v[2] + v[5] + v[8] - v[0] - v[3] - v[6];
                    term_b  = v[6] + v[7] + v[8] - v[0] - v[1] - v[2];
                    use_abs = 1'b1;
                end
                MODE_LAPLACE:
                begin
                    term_a = (v[4] <<< 2) + v[4] - (v[1] + v[3] + v[5] + v[7]);
                end
                default:
                begin
                    term_a = v[4];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        term_a_reg  <= term_a;
        term_b_reg  <= term_b;
        use_abs_reg <= use_abs;
    end

    always_comb
    begin
        mag_a = (use_abs_reg && term_a_reg < 0) ? -term_a_reg : term_a_reg;
        mag_b = (use_abs_reg && term_b_reg < 0) ? -term_b_reg : term_b_reg;
        total = mag_a + mag_b;
        if (total < 0)
            result = '0;
        else if (total > CH_MAX)
            result = CH_MAX[PIXEL_BITS-1:0];
        else
            result = total[PIXEL_BITS-1:0];
    end

endmodule

// ----- sv/spl_outq.sv -----
`timescale 1ns / 1ps
// spl_outq: merges the three lane results with frame end into one result
// and queues it; credit count backs up the input. Depends on spl_pkg.
module spl_outq
    import spl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      reserve,
    input  logic      wr,
    input  chan_t     blue,
    input  chan_t     green,
    input  chan_t     red,
    input  logic      fend,
    output logic      full,
    output logic      out_vld,
    input  logic      out_stall,
    output out_item_t rd_item
);

    localparam int CW = OQ_AW + 1;

    out_item_t      q_mem [OQ_DEPTH];
    out_item_t      wr_item;
    logic [OQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  fill_reg, credit_reg;
    logic           pop;

    always_comb
    begin
        wr_item.px.blue  = blue;
        wr_item.px.green = green;
        wr_item.px.red   = red;
        wr_item.fend     = fend;
    end

    assign out_vld = (fill_reg != '0);
    assign pop     = out_vld && !out_stall;
    assign full    = (credit_reg == CW'(OQ_DEPTH));
    assign rd_item = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            q_mem[wr_ptr_reg] <= wr_item;
    end

    // credits count results reserved at input transfer until they leave
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg   <= fill_reg + CW'(wr) - CW'(pop);
            credit_reg <= credit_reg + CW'(reserve) - CW'(pop);
        end
    end

endmodule

// ----- sv/sobel_prewitt_laplace_edge_filter.sv -----
`timescale 1ns / 1ps
// Top level of the 3x3 Sobel / Prewitt / Laplace edge filter for BGR pixels.
// Depends on spl_pkg, spl_pos, spl_window, spl_lane, spl_outq.
//
//  port group   dir  handshake             payload
//  cfg          in   cfg_en                cfg_addr, cfg_data
//  in           in   in_valid / in_stall   action, blue_in, green_in, red_in
//  out          out  out_valid / out_stall blue_out, green_out, red_out, frame_end
//
// One pixel per clock sustained while out_stall stays low. A result raises out_valid
// once the input that completes its window (image_width+1 items on) has passed the
// window, lane and result queue registers, and transfers while out_stall is low.
// Line stores need no clearing after reset; counters and window reset to zero.
// An 8-entry result queue with credit count drives in_stall: input stalls only
// once eight results are owed and not yet taken.
module sobel_prewitt_laplace_edge_filter
    import spl_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  chan_t             blue_in,
    input  chan_t             green_in,
    input  chan_t             red_in,
    output logic              out_valid,
    input  logic              out_stall,
    output chan_t             blue_out,
    output chan_t             green_out,
    output chan_t             red_out,
    output logic              frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [MODE_BITS-1:0]   mode_reg;

    logic         in_acc, q_full;
    logic [AW-1:0] col;
    pixel_t       pix;
    item_ctl_t    ctl_in, ctl_w, ctl_l_reg;
    pixel_t [8:0] win;
    chan_t [8:0]  win_b, win_g, win_r;
    chan_t        res_b, res_g, res_r;
    out_item_t    rd_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            mode_reg   <= MODE_SOBEL;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_BITS-1:0];
                REG_FILTER_MODE:  mode_reg   <= cfg_data[MODE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign in_stall = q_full;
    assign in_acc   = in_valid && !in_stall;

    // flush items enter as a black pixel
    always_comb
    begin
        pix.blue  = action ? '0 : blue_in;
        pix.green = action ? '0 : green_in;
        pix.red   = action ? '0 : red_in;
    end

    spl_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (in_acc),
        .image_width  (width_reg),
        .image_height (height_reg),
        .col          (col),
        .ctl          (ctl_in)
    );

    spl_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (in_acc),
        .col     (col),
        .pix     (pix),
        .ctl_in  (ctl_in),
        .win     (win),
        .ctl_out (ctl_w)
    );

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            win_b[k] = win[k].blue;
            win_g[k] = win[k].green;
            win_r[k] = win[k].red;
        end
    end

    spl_lane u_lane_b (
        .clk    (clk),
        .win    (win_b),
        .mode   (mode_reg),
        .border (ctl_w.border),
        .result (res_b)
    );

    spl_lane u_lane_g (
        .clk    (clk),
        .win    (win_g),
        .mode   (mode_reg),
        .border (ctl_w.border),
        .result (res_g)
    );

    spl_lane u_lane_r (
        .clk    (clk),
        .win    (win_r),
        .mode   (mode_reg),
        .border (ctl_w.border),
        .result (res_r)
    );

    // control follows the lane register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_l_reg <= '0;
        else
            ctl_l_reg <= ctl_w;
    end

    spl_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .reserve   (in_acc && ctl_in.vld),
        .wr        (ctl_l_reg.vld),
        .blue      (res_b),
        .green     (res_g),
        .red       (res_r),
        .fend      (ctl_l_reg.fend),
        .full      (q_full),
        .out_vld   (out_valid),
        .out_stall (out_stall),
        .rd_item   (rd_item)
    );

    assign blue_out  = rd_item.px.blue;
    assign green_out = rd_item.px.green;
    assign red_out   = rd_item.px.red;
    assign frame_end = rd_item.fend;

endmodule

// ----- sv/spl_chk.sv -----
`timescale 1ns / 1ps
// spl_chk: port-level checks for the edge filter, bound to the top level.
// Depends on sobel_prewitt_laplace_edge_filter port names only.
module spl_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] blue_out,
    input logic [7:0] green_out,
    input logic [7:0] red_out,
    input logic       frame_end
);

    // held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(blue_out) && $stable(green_out)
            && $stable(red_out) && $stable(frame_end))
        else $error("stalled result changed");

    // input backs up only when results are waiting at the output
    a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty result queue");

    // an empty queue refills only from an input transfer passed through the window and lane registers
    a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 4))
        else $error("result appeared without matching input transfer");

endmodule

bind sobel_prewitt_laplace_edge_filter spl_chk u_spl_chk (.*);
